// ----- rtl/psg_board_port_decoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// psg board port decoder assertion macros
// shared property forms for the checker of the decoder core
// ----------------------------------------------------------------------------
`ifndef PSG_BOARD_PORT_DECODER_CORE_MACROS_SVH
`define PSG_BOARD_PORT_DECODER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, idle while rst_n is low
`define PBPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, idle while rst_n is low
`define PBPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pbpd_pkg.sv -----
// ----------------------------------------------------------------------------
// pbpd_pkg
// types and constants of the psg board port decoder
// ----------------------------------------------------------------------------
package pbpd_pkg;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        PORT_ADDR_A = 2'd0,
        PORT_ADDR_B = 2'd1,
        PORT_DATA_A = 2'd2,
        PORT_DATA_B = 2'd3
    } port_t;

    typedef enum logic [2:0]
    {
        ACT_NONE   = 3'd0,
        ACT_WR1    = 3'd1,
        ACT_WR2    = 3'd2,
        ACT_WR3    = 3'd3,
        ACT_RHYTHM = 3'd4,
        ACT_RDATA  = 3'd5,
        ACT_RD1    = 3'd6,
        ACT_RD2    = 3'd7
    } action_t;

    localparam logic [7:0] ADDR_LIMIT    = 8'h0e;
    localparam logic [7:0] ADDR_IO       = 8'h0f;
    localparam logic [7:0] IO_EDGE_MASK  = 8'hc2;
    localparam logic [7:0] IO_LATCH_CODE = 8'h42;
    localparam logic [7:0] IO_WRITE_CODE = 8'h40;
    localparam logic [7:0] RHYTHM_MASK   = 8'h0f;
    localparam logic [7:0] OPEN_BUS      = 8'hff;

    typedef struct packed
    {
        op_t        op;
        port_t      port_sel;
        logic [7:0] wdata;
    } req_t;

    typedef struct packed
    {
        action_t    action;
        logic [3:0] chip_reg;
        logic [7:0] chip_data;
    } res_t;

    typedef struct packed
    {
        logic [7:0] addr_latch_a;
        logic [7:0] addr_latch_b;
        logic [7:0] io_reg_a;
        logic [7:0] io_reg_b;
        logic [7:0] third_chip_addr;
    } state_t;

endpackage

// ----- rtl/psg_board_port_decoder_core.sv -----
// ----------------------------------------------------------------------------
// psg_board_port_decoder_core
// bus-side port decoder of a three-chip tone board, stream in, stream out
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata                         tuser
//  s_axis    in    wdata                         op, port_sel
//  m_axis    out   chip_reg, chip_data           action
//
//  every request yields exactly one result; an accepted request waits in the
//  request register and is offered once it loads into the result register
//  one request per cycle is taken while s_axis_tready is high; the decode
//  is a single pass between the request register and the result register,
//  and the board state updates in the same cycle as the result register loads
//  a stalled result holds the request register; s_axis_tready drops only
//  while both registers are full and m_axis_tready is low
//  rst_n clears the valid flags, both address latches, both io bytes and
//  the chip-3 address
//
module psg_board_port_decoder_core
    import pbpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // wdata[7:0]
    input  logic [2:0]  s_axis_tuser,   // op[0], port_sel[2:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // chip_reg[3:0], chip_data[11:4], zero[15:12]
    output logic [2:0]  m_axis_tuser    // action[2:0]
);

    // request stage
    logic   in_valid_reg;
    logic   in_valid_next;
    req_t   in_req_reg;

    // result stage
    logic   out_valid_reg;
    logic   out_valid_next;
    res_t   out_res_reg;

    // board state: address latches, io bytes, chip-3 address
    state_t state_reg;
    state_t state_next;
    res_t   dec_res;

    logic   s_accept;
    logic   advance;

    // request moves to the result register when that register is free or drains
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    pbpd_decode u_decode
    (
        .req        (in_req_reg),
        .state      (state_reg),
        .res        (dec_res),
        .state_next (state_next)
    );

    // control and board state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_req_reg.op       <= op_t'(s_axis_tuser[0]);
            in_req_reg.port_sel <= port_t'(s_axis_tuser[2:1]);
            in_req_reg.wdata    <= s_axis_tdata;
        end
        if (advance)
        begin
            out_res_reg <= dec_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.action;
    assign m_axis_tdata  = {4'd0, out_res_reg.chip_data, out_res_reg.chip_reg};

endmodule

// ----- rtl/pbpd_decode.sv -----
// ----------------------------------------------------------------------------
// pbpd_decode
// combinational decode of one bus request against the board state
// ----------------------------------------------------------------------------
module pbpd_decode
    import pbpd_pkg::*;
(
    input  req_t   req,
    input  state_t state,
    output res_t   res,
    output state_t state_next
);

    logic [7:0] addr;
    logic       is_a;
    logic       io_fall;
    logic [7:0] io_masked;
    logic [7:0] rhythm;

    assign is_a      = (req.port_sel == PORT_DATA_A);
    assign addr      = is_a ? state.addr_latch_a : state.addr_latch_b;
    assign io_fall   = state.io_reg_b[0] & ~req.wdata[0];
    assign io_masked = state.io_reg_b & IO_EDGE_MASK;
    assign rhythm    = state.io_reg_a & RHYTHM_MASK;

    always_comb
    begin
        res        = '{action: ACT_NONE, chip_reg: 4'd0, chip_data: 8'd0};
        state_next = state;
        if (req.op == OP_READ)
        begin
            if (req.port_sel == PORT_ADDR_A || req.port_sel == PORT_ADDR_B)
            begin
                res.action    = ACT_RDATA;
                res.chip_data = OPEN_BUS;
            end
            else if (addr < ADDR_LIMIT)
            begin
                res.action   = is_a ? ACT_RD1 : ACT_RD2;
                res.chip_reg = addr[3:0];
            end
            else if (addr == ADDR_IO)
            begin
                res.action    = ACT_RDATA;
                res.chip_data = is_a ? state.io_reg_a : state.io_reg_b;
            end
            else
            begin
                res.action    = ACT_RDATA;
                res.chip_data = OPEN_BUS;
            end
        end
        else
        begin
            case (req.port_sel)
                PORT_ADDR_A: state_next.addr_latch_a = req.wdata;
                PORT_ADDR_B: state_next.addr_latch_b = req.wdata;
                PORT_DATA_A:
                begin
                    if (addr < ADDR_LIMIT)
                    begin
                        res.action    = ACT_WR1;
                        res.chip_reg  = addr[3:0];
                        res.chip_data = req.wdata;
                    end
                    else if (addr == ADDR_IO)
                    begin
                        state_next.io_reg_a = req.wdata;
                    end
                end
                PORT_DATA_B:
                begin
                    if (addr < ADDR_LIMIT)
                    begin
                        res.action    = ACT_WR2;
                        res.chip_reg  = addr[3:0];
                        res.chip_data = req.wdata;
                    end
                    else if (addr == ADDR_IO)
                    begin
                        state_next.io_reg_b = req.wdata;
                        // falling edge on io bit 0 drives the chip-3 path
                        if (io_fall && io_masked == IO_LATCH_CODE)
                        begin
                            state_next.third_chip_addr = state.io_reg_a;
                        end
                        else if (io_fall && io_masked == IO_WRITE_CODE)
                        begin
                            if (state.third_chip_addr < ADDR_LIMIT)
                            begin
                                res.action    = ACT_WR3;
                                res.chip_reg  = state.third_chip_addr[3:0];
                                res.chip_data = state.io_reg_a;
                            end
                            else if (state.third_chip_addr == ADDR_IO && rhythm != 8'd0)
                            begin
                                res.action    = ACT_RHYTHM;
                                res.chip_data = rhythm;
                            end
                        end
                    end
                end
                default: state_next = state;
            endcase
        end
    end

endmodule

// ----- rtl/pbpd_checker.sv -----
// ----------------------------------------------------------------------------
// pbpd_checker
// port-level checks of the psg board port decoder core
// ----------------------------------------------------------------------------
`include "psg_board_port_decoder_core_macros.svh"

module pbpd_checker
    import pbpd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic        no_reg;
    logic        no_data;
    logic        res_stall;
    logic        is_rhythm;
    logic        rhythm_ok;
    logic [3:0]  res_reg;
    logic [7:0]  res_data;
    logic [18:0] res_word;

    assign no_reg    = (m_axis_tuser == ACT_NONE) || (m_axis_tuser == ACT_RHYTHM) ||
                       (m_axis_tuser == ACT_RDATA);
    assign no_data   = (m_axis_tuser == ACT_NONE) || (m_axis_tuser == ACT_RD1) ||
                       (m_axis_tuser == ACT_RD2);
    assign res_stall = m_axis_tvalid && !m_axis_tready;
    assign is_rhythm = m_axis_tvalid && (m_axis_tuser == ACT_RHYTHM);
    assign res_reg   = m_axis_tdata[3:0];
    assign res_data  = m_axis_tdata[11:4];
    assign res_word  = {m_axis_tuser, m_axis_tdata};
    assign rhythm_ok = (res_data[7:4] == 4'd0) && (res_data[3:0] != 4'd0);

    // stalled result holds its payload
    `PBPD_ASSERT_NEXT(a_hold, res_stall, $stable(res_word), "stalled result changed")

    // register index only on forwarded chip accesses
    `PBPD_ASSERT_SAME(a_reg_zero, m_axis_tvalid && no_reg, res_reg == 4'd0, "stray register index")

    // no data on idle or forwarded reads
    `PBPD_ASSERT_SAME(a_data_zero, m_axis_tvalid && no_data, res_data == 8'd0, "stray data")

    // rhythm mask is a nonzero low nibble
    `PBPD_ASSERT_SAME(a_rhythm, is_rhythm, rhythm_ok, "bad rhythm mask")

    // input only stalls behind a stalled result
    `PBPD_ASSERT_SAME(a_stall_src, !s_axis_tready, res_stall, "input stall without output stall")

endmodule

bind psg_board_port_decoder_core pbpd_checker u_pbpd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
